/* rtl/pfde_pkg.sv */
`timescale 1ns / 1ps

package pfde_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = 25;
	localparam int LETTERS = 26;

	localparam logic [4:0] LETTER_I       = 5'd8;
	localparam logic [4:0] LETTER_J       = 5'd9;
	localparam logic [4:0] LETTER_Z       = 5'd25;
	localparam logic [4:0] DEFAULT_FILLER = 5'd23;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] cell_idx_t;
	typedef logic [2:0] coord_t;

	// Input beat kinds
	typedef enum logic [1:0] {
		MODE_KEY    = 2'd0,
		MODE_FINISH = 2'd1,
		MODE_MSG    = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	// Commands handed from front to back
	typedef enum logic [1:0] {
		OP_KEY    = 2'd0,
		OP_FINISH = 2'd1,
		OP_PAIR   = 2'd2
	} op_t;

	typedef struct packed {
		op_t     op;
		letter_t a;
		letter_t b;
	} cmd_t;

	typedef struct packed {
		letter_t letter;
		logic    last;
	} res_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} rc_t;

	function automatic letter_t fold_j(input letter_t c);
		return (c == LETTER_J) ? LETTER_I : c;
	endfunction

	// Split a square position into row and column
	function automatic rc_t pos_split(input cell_idx_t pos);
		cell_idx_t p;
		rc_t       rc;
		p = (pos >= cell_idx_t'(CELLS)) ? pos - cell_idx_t'(CELLS) : pos;
		priority if (p >= 5'd20) begin
			rc.row = 3'd4;
			rc.col = 3'(p - 5'd20);
		end else if (p >= 5'd15) begin
			rc.row = 3'd3;
			rc.col = 3'(p - 5'd15);
		end else if (p >= 5'd10) begin
			rc.row = 3'd2;
			rc.col = 3'(p - 5'd10);
		end else if (p >= 5'd5) begin
			rc.row = 3'd1;
			rc.col = 3'(p - 5'd5);
		end else begin
			rc.row = 3'd0;
			rc.col = 3'(p);
		end
		return rc;
	endfunction

	function automatic coord_t wrap_inc(input coord_t v);
		return (v == coord_t'(SIDE - 1)) ? 3'd0 : v + 3'd1;
	endfunction

	function automatic cell_idx_t cell_addr(input coord_t r, input coord_t c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

/* rtl/pfde_front.sv */
`timescale 1ns / 1ps

module pfde_front import pfde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_mode,
	input  letter_t    in_letter,
	input  logic       cfg_we,
	input  letter_t    cfg_wdata,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	letter_t filler_q;
	letter_t held_q;
	logic    held_valid_q;
	letter_t filler_eff;
	letter_t folded;
	letter_t second;
	logic    in_range;
	logic    accept;
	mode_t   mode;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign mode     = mode_t'(in_mode);
	assign in_range = (in_letter <= LETTER_Z);
	assign folded   = fold_j(in_letter);

	// Hold the filler register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q <= DEFAULT_FILLER;
		end else if (cfg_we) begin
			filler_q <= cfg_wdata;
		end
	end

	assign filler_eff = fold_j((filler_q > LETTER_Z) ? DEFAULT_FILLER : filler_q);
	assign second     = (folded == held_q) ? filler_eff : folded;

	// Classify the beat and build the command
	always_comb begin
		q_push = 1'b0;
		q_cmd  = '{op: OP_KEY, a: folded, b: second};
		unique case (mode)
			MODE_KEY: begin
				q_push = accept && in_range;
			end
			MODE_FINISH: begin
				q_push   = accept;
				q_cmd.op = OP_FINISH;
			end
			MODE_MSG: begin
				q_push = accept && in_range && held_valid_q;
				q_cmd  = '{op: OP_PAIR, a: held_q, b: second};
			end
			MODE_END: begin
				q_push = accept && held_valid_q;
				q_cmd  = '{op: OP_PAIR, a: held_q, b: filler_eff};
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Track the pending first letter of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_q       <= '0;
		end else if (accept) begin
			if (mode == MODE_MSG && in_range) begin
				held_valid_q <= !held_valid_q;
				if (!held_valid_q) begin
					held_q <= folded;
				end
			end else if (mode == MODE_END) begin
				held_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/pfde_fifo.sv */
`timescale 1ns / 1ps

module pfde_fifo import pfde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_cmd
);

	cmd_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_cmd   = entry_q[rd_q];

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= !wr_q;
			end
			if (pop && not_empty) begin
				rd_q <= !rd_q;
			end
			unique case ({push && !full, pop && not_empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/pfde_back.sv */
`timescale 1ns / 1ps

module pfde_back import pfde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FILL = 5'b00010,
		ST_CALC = 5'b00100,
		ST_OUT0 = 5'b01000,
		ST_OUT1 = 5'b10000
	} state_t;

	state_t    state_q;
	letter_t   square [CELLS];
	cell_idx_t position_of [LETTERS];
	logic [LETTERS-1:0] used_q;
	cell_idx_t fill_q;
	letter_t   walk_q;
	cell_idx_t pos_a_q;
	cell_idx_t pos_b_q;
	letter_t   sq_x_q;
	letter_t   sq_y_q;

	logic      place_req;
	letter_t   place_c;
	logic      place_ok;
	rc_t       rc_a;
	rc_t       rc_b;
	cell_idx_t addr_x;
	cell_idx_t addr_y;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// Select a letter to place: a key letter or the fill walk
	always_comb begin
		place_req = 1'b0;
		place_c   = q_cmd.a;
		if (q_pop && q_cmd.op == OP_KEY) begin
			place_req = 1'b1;
		end else if (state_q == ST_FILL) begin
			place_req = (walk_q != LETTER_J);
			place_c   = walk_q;
		end
	end

	assign place_ok = place_req && !used_q[place_c] && (fill_q < cell_idx_t'(CELLS));

	// Write the square and the position table
	always_ff @(posedge clk) begin
		if (place_ok) begin
			square[fill_q]       <= place_c;
			position_of[place_c] <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
		end else if (place_ok) begin
			used_q[place_c] <= 1'b1;
			fill_q          <= fill_q + 5'd1;
		end
	end

	// Read both positions when a pair is popped
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.op == OP_PAIR) begin
			pos_a_q <= position_of[q_cmd.a];
			pos_b_q <= position_of[q_cmd.b];
		end
	end

	// Pick cells by the column, row or rectangle rule
	always_comb begin
		rc_a = pos_split(pos_a_q);
		rc_b = pos_split(pos_b_q);
		priority if (rc_a.col == rc_b.col) begin
			addr_x = cell_addr(wrap_inc(rc_a.row), rc_a.col);
			addr_y = cell_addr(wrap_inc(rc_b.row), rc_b.col);
		end else if (rc_a.row == rc_b.row) begin
			addr_x = cell_addr(rc_a.row, wrap_inc(rc_a.col));
			addr_y = cell_addr(rc_b.row, wrap_inc(rc_b.col));
		end else begin
			addr_x = cell_addr(rc_a.row, rc_b.col);
			addr_y = cell_addr(rc_b.row, rc_a.col);
		end
	end

	// Read both cipher letters
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			sq_x_q <= square[addr_x];
			sq_y_q <= square[addr_y];
		end
	end

	// Emit the pair
	always_comb begin
		res_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		res       = (state_q == ST_OUT1) ? res_t'{letter: sq_y_q, last: 1'b1}
		                                 : res_t'{letter: sq_x_q, last: 1'b0};
	end

	// Sequence the commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op)
							OP_FINISH: begin
								state_q <= ST_FILL;
								walk_q  <= '0;
							end
							OP_PAIR: state_q <= ST_CALC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FILL: begin
					walk_q <= walk_q + 5'd1;
					if (walk_q == LETTER_Z) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: state_q <= ST_OUT0;
				ST_OUT0: begin
					if (res_ready) begin
						state_q <= ST_OUT1;
					end
				end
				ST_OUT1: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/playfair_digraph_encryptor.sv */
`timescale 1ns / 1ps
// Playfair digraph encryptor.
// Input stream: tuser carries the beat kind (key letter, finish key, message
// letter, end of message), tdata the letter index a=0..z=25 with j read as i.
// Key letters build the 5x5 square in order, skipping repeats; finish key
// fills the rest in alphabet order. Message letters are paired and each pair
// returns two output beats, the cipher letters, with tlast on the second.
// cfg_we/cfg_wdata set the filler letter (reset x); write it only when idle.
// A front stage pairs letters and pushes commands into a two-entry queue;
// the back sequencer runs them against the square and position memories.
// Back steps: a key letter is placed when it is popped, finish key walks
// the alphabet one letter per cycle, and a pair passes the position read,
// the square read and two output beats on its way to the output register.
// The input takes a beat per cycle while the queue has room.
// Reset clears the queue, the pairing state and the used-letter set; the
// square needs no clearing pass. When the receiver stalls, the output
// register holds its beat, the back halts, and the queue fills and then
// drops s_axis_tready.

module playfair_digraph_encryptor import pfde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [4:0] letter
	input  logic [1:0] s_axis_tuser,  // [1:0] mode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [4:0] cipher_letter
	output logic       m_axis_tlast,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	pfde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_letter (s_axis_tdata[4:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	pfde_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_cmd   (pop_cmd)
	);

	pfde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.letter};
	assign m_axis_tlast  = out_q.last;

endmodule

/* rtl/pfde_checker.sv */
`timescale 1ns / 1ps

module pfde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic second_q;

	// Track which half of a pair the next output beat is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			second_q <= !second_q;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> m_axis_tlast == second_q)
		else $error("output beats out of pair order");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
		else $error("output padding bits set");

endmodule

bind playfair_digraph_encryptor pfde_checker u_pfde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
